>>> src/bcg_pkg.sv
// shared types and constants for the button click gesture detector
package bcg_pkg;

    localparam int unsigned LEN_WIDTH = 16;
    localparam int unsigned CFG_INDEX_WIDTH = 3;

    localparam logic PRESSED_LEVEL = 1'b0;

    typedef enum logic [1:0] {
        GESTURE_NONE   = 2'd0,
        GESTURE_CLICK  = 2'd1,
        GESTURE_DOUBLE = 2'd2,
        GESTURE_LONG   = 2'd3
    } t_gesture;

    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        CFG_DEBOUNCE_TICKS      = 3'd0,
        CFG_LONG_PRESS_TICKS    = 3'd1,
        CFG_DOUBLE_CLICK_TICKS  = 3'd2,
        CFG_CLICK_ENABLE        = 3'd3,
        CFG_DOUBLE_CLICK_ENABLE = 3'd4,
        CFG_LONG_PRESS_ENABLE   = 3'd5
    } t_cfg_index;

endpackage

>>> src/bcg_tick_counter.sv
// saturating tick counter step with window end detection
module bcg_tick_counter #(
    parameter int unsigned COUNT_WIDTH = 16
) (
    input  logic [COUNT_WIDTH-1:0]          i_count,
    input  logic [bcg_pkg::LEN_WIDTH-1:0]   i_length,
    output logic [COUNT_WIDTH-1:0]          o_count,
    output logic                            o_done
);
    import bcg_pkg::*;

    localparam int unsigned CMP_WIDTH = (COUNT_WIDTH > LEN_WIDTH) ? COUNT_WIDTH : LEN_WIDTH;

    logic                  at_top;
    logic [CMP_WIDTH-1:0]  count_ext;
    logic [CMP_WIDTH-1:0]  length_ext;

    assign at_top     = &i_count;
    assign o_count    = at_top ? i_count : i_count + {{(COUNT_WIDTH-1){1'b0}}, 1'b1};
    assign count_ext  = CMP_WIDTH'(o_count);
    assign length_ext = CMP_WIDTH'(i_length);
    // a window also ends once the counter is pinned at full scale
    assign o_done     = (count_ext >= length_ext) || (&o_count);

endmodule

>>> src/button_click_gesture_detector.sv
// top level of the debounced click, double click and long press detector
//
//  channel | signals                                      | direction
//  --------+----------------------------------------------+----------
//  sample  | i_valid, o_ready, i_pin_level                | in
//  result  | o_valid, i_ready, o_gesture, o_button_down   | out
//  config  | i_cfg_valid, o_cfg_ready, i_cfg_index/data   | in
//
// one sample per clock while the result side takes words; the whole tick update
// is one pass of logic from the state registers into the result register.
// the result register frees up when taken, so o_ready stays high while the
// consumer takes every word; a stalled result holds the sample side only.
// synchronous active-low reset restores the power-on state and config values; the result payload is not reset.
// config writes are always taken (o_cfg_ready high).
module button_click_gesture_detector #(
    parameter int unsigned COUNT_WIDTH = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    output logic                                  o_ready,
    input  logic                                  i_pin_level,
    output logic                                  o_valid,
    input  logic                                  i_ready,
    output logic [1:0]                            o_gesture,
    output logic                                  o_button_down,
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [bcg_pkg::CFG_INDEX_WIDTH-1:0]   i_cfg_index,
    input  logic [bcg_pkg::LEN_WIDTH-1:0]         i_cfg_data
);
    import bcg_pkg::*;

    // configuration
    logic [LEN_WIDTH-1:0] r_debounce_ticks;
    logic [LEN_WIDTH-1:0] r_long_press_ticks;
    logic [LEN_WIDTH-1:0] r_double_click_ticks;
    logic                 r_click_enable;
    logic                 r_double_click_enable;
    logic                 r_long_press_enable;

    // tick state
    logic                   r_previous_sample, n_previous_sample;
    logic                   r_debounce_active, n_debounce_active;
    logic                   r_captured_level,  n_captured_level;
    logic [COUNT_WIDTH-1:0] r_debounce_count,  n_debounce_count;
    logic                   r_awaiting_release, n_awaiting_release;
    logic                   r_timing_press,    n_timing_press;
    logic                   r_timing_release,  n_timing_release;
    logic                   r_double_pending,  n_double_pending;
    logic                   r_hold_running,    n_hold_running;
    logic [COUNT_WIDTH-1:0] r_hold_count,      n_hold_count;

    // result register
    logic     r_out_valid;
    t_gesture r_gesture, n_gesture;
    logic     r_button_down;

    // state after the debounce expiry step
    logic                   d_debounce_active;
    logic                   d_awaiting_release;
    logic                   d_timing_press;
    logic                   d_timing_release;
    logic                   d_double_pending;
    logic                   d_hold_running;
    logic [COUNT_WIDTH-1:0] d_hold_count;
    logic [COUNT_WIDTH-1:0] d_debounce_count;
    logic                   d_armed;
    t_gesture               d_gesture;

    logic                   accept;
    logic [COUNT_WIDTH-1:0] db_count_step;
    logic                   db_done;
    logic [COUNT_WIDTH-1:0] hold_count_step;
    logic                   hold_done;
    logic [LEN_WIDTH-1:0]   hold_length;
    logic                   toward_press;
    logic                   toward_release;

    assign o_ready       = !r_out_valid || i_ready;
    assign accept        = i_valid && o_ready;
    assign o_cfg_ready   = 1'b1;
    assign o_valid       = r_out_valid;
    assign o_gesture     = r_gesture;
    assign o_button_down = r_button_down;

    bcg_tick_counter #(.COUNT_WIDTH(COUNT_WIDTH)) u_debounce_counter (
        .i_count  (r_debounce_count),
        .i_length (r_debounce_ticks),
        .o_count  (db_count_step),
        .o_done   (db_done)
    );

    assign hold_length = d_timing_press ? r_long_press_ticks : r_double_click_ticks;

    bcg_tick_counter #(.COUNT_WIDTH(COUNT_WIDTH)) u_hold_counter (
        .i_count  (r_hold_count),
        .i_length (hold_length),
        .o_count  (hold_count_step),
        .o_done   (hold_done)
    );

    // debounce window expiry
    always_comb begin
        d_debounce_active  = r_debounce_active;
        d_debounce_count   = r_debounce_count;
        d_awaiting_release = r_awaiting_release;
        d_timing_press     = r_timing_press;
        d_timing_release   = r_timing_release;
        d_double_pending   = r_double_pending;
        d_hold_running     = r_hold_running;
        d_hold_count       = r_hold_count;
        d_armed            = 1'b0;
        d_gesture          = GESTURE_NONE;
        if (r_debounce_active) begin
            d_debounce_count = db_count_step;
            if (db_done) begin
                d_debounce_active = 1'b0;
                if (i_pin_level == r_captured_level) begin
                    d_hold_running = 1'b0;
                    if (i_pin_level == PRESSED_LEVEL) begin
                        if (r_timing_release) begin
                            // second press inside the window
                            d_timing_release = 1'b0;
                            d_double_pending = 1'b1;
                        end else begin
                            d_timing_press = 1'b1;
                            d_hold_running = 1'b1;
                            d_hold_count   = '0;
                            d_armed        = 1'b1;
                        end
                        d_awaiting_release = 1'b1;
                    end else begin
                        if (r_double_pending) begin
                            if (r_double_click_enable) begin
                                d_gesture = GESTURE_DOUBLE;
                            end
                            d_double_pending = 1'b0;
                        end
                        if (r_timing_press) begin
                            d_timing_press   = 1'b0;
                            d_timing_release = 1'b1;
                            d_hold_running   = 1'b1;
                            d_hold_count     = '0;
                            d_armed          = 1'b1;
                        end
                        d_awaiting_release = 1'b0;
                    end
                end
            end
        end
    end

    // hold timer expiry, then edge detection
    always_comb begin
        n_debounce_active  = d_debounce_active;
        n_debounce_count   = d_debounce_count;
        n_captured_level   = r_captured_level;
        n_awaiting_release = d_awaiting_release;
        n_timing_press     = d_timing_press;
        n_timing_release   = d_timing_release;
        n_double_pending   = d_double_pending;
        n_hold_running     = d_hold_running;
        n_hold_count       = d_hold_count;
        n_gesture          = d_gesture;
        n_previous_sample  = i_pin_level;
        if (d_hold_running && !d_armed) begin
            n_hold_count = hold_count_step;
            if (hold_done) begin
                n_hold_running = 1'b0;
                if (d_timing_press) begin
                    if (r_long_press_enable) begin
                        n_gesture = GESTURE_LONG;
                    end
                    n_timing_press = 1'b0;
                end
                if (d_timing_release) begin
                    if (r_click_enable) begin
                        n_gesture = GESTURE_CLICK;
                    end
                    n_timing_release = 1'b0;
                end
            end
        end
        toward_press   = (i_pin_level == PRESSED_LEVEL) && !d_awaiting_release;
        toward_release = (i_pin_level != PRESSED_LEVEL) && d_awaiting_release;
        if ((i_pin_level != r_previous_sample) && !d_debounce_active
                && (toward_press || toward_release)) begin
            n_captured_level  = i_pin_level;
            n_debounce_active = 1'b1;
            n_debounce_count  = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce_ticks      <= LEN_WIDTH'(20);
            r_long_press_ticks    <= LEN_WIDTH'(1000);
            r_double_click_ticks  <= LEN_WIDTH'(300);
            r_click_enable        <= 1'b0;
            r_double_click_enable <= 1'b0;
            r_long_press_enable   <= 1'b0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_DEBOUNCE_TICKS:      r_debounce_ticks      <= i_cfg_data;
                CFG_LONG_PRESS_TICKS:    r_long_press_ticks    <= i_cfg_data;
                CFG_DOUBLE_CLICK_TICKS:  r_double_click_ticks  <= i_cfg_data;
                CFG_CLICK_ENABLE:        r_click_enable        <= i_cfg_data[0];
                CFG_DOUBLE_CLICK_ENABLE: r_double_click_enable <= i_cfg_data[0];
                CFG_LONG_PRESS_ENABLE:   r_long_press_enable   <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_previous_sample  <= 1'b1;
            r_debounce_active  <= 1'b0;
            r_captured_level   <= 1'b0;
            r_debounce_count   <= '0;
            r_awaiting_release <= 1'b0;
            r_timing_press     <= 1'b0;
            r_timing_release   <= 1'b0;
            r_double_pending   <= 1'b0;
            r_hold_running     <= 1'b0;
            r_hold_count       <= '0;
            r_out_valid        <= 1'b0;
        end else begin
            if (accept) begin
                r_previous_sample  <= n_previous_sample;
                r_debounce_active  <= n_debounce_active;
                r_captured_level   <= n_captured_level;
                r_debounce_count   <= n_debounce_count;
                r_awaiting_release <= n_awaiting_release;
                r_timing_press     <= n_timing_press;
                r_timing_release   <= n_timing_release;
                r_double_pending   <= n_double_pending;
                r_hold_running     <= n_hold_running;
                r_hold_count       <= n_hold_count;
                r_out_valid        <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result word payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_gesture     <= n_gesture;
            r_button_down <= n_awaiting_release;
        end
    end

endmodule

>>> sim/tb.sv
// testbench for the button gesture detector: a directed table, a long hold, random phases
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import bcg_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 1_000_000;
    localparam int unsigned NUM_PHASES  = 10;
    localparam int          PHASE_WORDS = 70;
    localparam int          LONG_HOLD   = 50;
    localparam int          NUM_STEPS   = 31;

    typedef struct {
        t_gesture gesture;
        logic     down;
    } tick_result_t;

    typedef struct packed {
        logic                 is_cfg;
        t_cfg_index           idx;
        logic [LEN_WIDTH-1:0] data;
        logic                 pin;
        logic                 typed;
        t_gesture             gesture;
        logic                 down;
    } step_t;

    // typed results only right after reset; every other row goes through the tracker
    localparam step_t DIRECTED_STEPS [NUM_STEPS] = '{
        '{1'b0, CFG_DEBOUNCE_TICKS,      16'h0000, 1'b1, 1'b1, GESTURE_NONE, 1'b0},
        '{1'b0, CFG_DEBOUNCE_TICKS,      16'h0000, 1'b0, 1'b1, GESTURE_NONE, 1'b0},
        // zero length behaves as one tick
        '{1'b1, CFG_DEBOUNCE_TICKS,      16'h0000, 1'b1, 1'b0, GESTURE_NONE, 1'b0},
        '{1'b1, CFG_LONG_PRESS_TICKS,    16'd3,    1'b1, 1'b0, GESTURE_NONE, 1'b0},
        '{1'b1, CFG_DOUBLE_CLICK_TICKS,  16'd2,    1'b1, 1'b0, GESTURE_NONE, 1'b0},
        // upper data bits of the enables are dropped
        '{1'b1, CFG_CLICK_ENABLE,        16'hFFFF, 1'b1, 1'b0, GESTURE_NONE, 1'b0},
        '{1'b1, CFG_DOUBLE_CLICK_ENABLE, 16'h0003, 1'b1, 1'b0, GESTURE_NONE, 1'b0},
        '{1'b1, CFG_LONG_PRESS_ENABLE,   16'h8001, 1'b1, 1'b0, GESTURE_NONE, 1'b0},
        // single click
        '{1'b0, CFG_DEBOUNCE_TICKS,      16'h0000, 1'b0, 1'b0, GESTURE_NONE, 1'b0},
        '{1'b0, CFG_DEBOUNCE_TICKS,      16'h0000, 1'b1, 1'b0, GESTURE_NONE, 1'b0},
        '{1'b0, CFG_DEBOUNCE_TICKS,      16'h0000, 1'b1, 1'b0, GESTURE_NONE, 1'b0},
        '{1'b0, CFG_DEBOUNCE_TICKS,      16'h0000, 1'b1, 1'b0, GESTURE_NONE, 1'b0},
        '{1'b0, CFG_DEBOUNCE_TICKS,      16'h0000, 1'b1, 1'b0, GESTURE_NONE, 1'b0},
        // double click
        '{1'b0, CFG_DEBOUNCE_TICKS,      16'h0000, 1'b0, 1'b0, GESTURE_NONE, 1'b0},
        '{1'b0, CFG_DEBOUNCE_TICKS,      16'h0000, 1'b0, 1'b0, GESTURE_NONE, 1'b0},
        '{1'b0, CFG_DEBOUNCE_TICKS,      16'h0000, 1'b1, 1'b0, GESTURE_NONE, 1'b0},
        '{1'b0, CFG_DEBOUNCE_TICKS,      16'h0000, 1'b1, 1'b0, GESTURE_NONE, 1'b0},
        '{1'b0, CFG_DEBOUNCE_TICKS,      16'h0000, 1'b0, 1'b0, GESTURE_NONE, 1'b0},
        '{1'b0, CFG_DEBOUNCE_TICKS,      16'h0000, 1'b0, 1'b0, GESTURE_NONE, 1'b0},
        '{1'b0, CFG_DEBOUNCE_TICKS,      16'h0000, 1'b1, 1'b0, GESTURE_NONE, 1'b0},
        '{1'b0, CFG_DEBOUNCE_TICKS,      16'h0000, 1'b1, 1'b0, GESTURE_NONE, 1'b0},
        // long press, then release
        '{1'b0, CFG_DEBOUNCE_TICKS,      16'h0000, 1'b0, 1'b0, GESTURE_NONE, 1'b0},
        '{1'b0, CFG_DEBOUNCE_TICKS,      16'h0000, 1'b0, 1'b0, GESTURE_NONE, 1'b0},
        '{1'b0, CFG_DEBOUNCE_TICKS,      16'h0000, 1'b0, 1'b0, GESTURE_NONE, 1'b0},
        '{1'b0, CFG_DEBOUNCE_TICKS,      16'h0000, 1'b0, 1'b0, GESTURE_NONE, 1'b0},
        '{1'b0, CFG_DEBOUNCE_TICKS,      16'h0000, 1'b0, 1'b0, GESTURE_NONE, 1'b0},
        '{1'b0, CFG_DEBOUNCE_TICKS,      16'h0000, 1'b1, 1'b0, GESTURE_NONE, 1'b0},
        '{1'b0, CFG_DEBOUNCE_TICKS,      16'h0000, 1'b1, 1'b0, GESTURE_NONE, 1'b0},
        // pin bounces back before the window ends
        '{1'b0, CFG_DEBOUNCE_TICKS,      16'h0000, 1'b0, 1'b0, GESTURE_NONE, 1'b0},
        '{1'b0, CFG_DEBOUNCE_TICKS,      16'h0000, 1'b1, 1'b0, GESTURE_NONE, 1'b0},
        '{1'b0, CFG_DEBOUNCE_TICKS,      16'h0000, 1'b1, 1'b0, GESTURE_NONE, 1'b0}
    };

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_valid;
    logic                 o_ready;
    logic                 i_pin_level;
    logic                 o_valid;
    logic                 i_ready;
    logic [1:0]           o_gesture;
    logic                 o_button_down;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    t_cfg_index           i_cfg_index;
    logic [LEN_WIDTH-1:0] i_cfg_data;

    // tracked configuration
    logic [LEN_WIDTH-1:0] cfg_debounce;
    logic [LEN_WIDTH-1:0] cfg_long;
    logic [LEN_WIDTH-1:0] cfg_double;
    logic                 en_click;
    logic                 en_double;
    logic                 en_long;

    // tracked detector state
    logic                 prev_pin;
    logic                 db_busy;
    logic                 db_level;
    logic [LEN_WIDTH-1:0] db_count;
    logic                 held;
    logic                 wait_press;
    logic                 wait_release;
    logic                 dbl_armed;
    logic                 hold_on;
    logic [LEN_WIDTH-1:0] hold_cnt;

    tick_result_t tick_results [$];
    int           samples_sent = 0;
    int           mismatches   = 0;
    int           idle_pct     = 0;
    int           stall_pct    = 0;
    int unsigned  cycle_count  = 0;

    button_click_gesture_detector DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_pin_level   (i_pin_level),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_gesture     (o_gesture),
        .o_button_down (o_button_down),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic logic [LEN_WIDTH-1:0] count_up(input logic [LEN_WIDTH-1:0] c);
        return (c == '1) ? c : c + 1'b1;
    endfunction

    task automatic reset_tracker();
        cfg_debounce = 16'd20;
        cfg_long     = 16'd1000;
        cfg_double   = 16'd300;
        en_click     = 1'b0;
        en_double    = 1'b0;
        en_long      = 1'b0;
        prev_pin     = ~PRESSED_LEVEL;
        db_busy      = 1'b0;
        db_level     = 1'b0;
        db_count     = '0;
        held         = 1'b0;
        wait_press   = 1'b0;
        wait_release = 1'b0;
        dbl_armed    = 1'b0;
        hold_on      = 1'b0;
        hold_cnt     = '0;
    endtask

    // one tick: window expiry, then the hold timer, then the edge
    task automatic track_tick(input logic pin, output t_gesture g, output logic down);
        logic                 armed;
        logic [LEN_WIDTH-1:0] len;
        g     = GESTURE_NONE;
        armed = 1'b0;
        if (db_busy) begin
            db_count = count_up(db_count);
            if (db_count >= cfg_debounce || db_count == '1) begin
                db_busy = 1'b0;
                if (pin == db_level) begin
                    hold_on = 1'b0;
                    if (pin == PRESSED_LEVEL) begin
                        if (wait_release) begin
                            wait_release = 1'b0;
                            dbl_armed    = 1'b1;
                        end else begin
                            wait_press = 1'b1;
                            hold_on    = 1'b1;
                            hold_cnt   = '0;
                            armed      = 1'b1;
                        end
                        held = 1'b1;
                    end else begin
                        if (dbl_armed) begin
                            if (en_double) g = GESTURE_DOUBLE;
                            dbl_armed = 1'b0;
                        end
                        if (wait_press) begin
                            wait_press   = 1'b0;
                            wait_release = 1'b1;
                            hold_on      = 1'b1;
                            hold_cnt     = '0;
                            armed        = 1'b1;
                        end
                        held = 1'b0;
                    end
                end
            end
        end
        // a timer armed this tick starts counting on the next one
        if (hold_on && !armed) begin
            len      = wait_press ? cfg_long : cfg_double;
            hold_cnt = count_up(hold_cnt);
            if (hold_cnt >= len || hold_cnt == '1) begin
                hold_on = 1'b0;
                if (wait_press) begin
                    if (en_long) g = GESTURE_LONG;
                    wait_press = 1'b0;
                end
                if (wait_release) begin
                    if (en_click) g = GESTURE_CLICK;
                    wait_release = 1'b0;
                end
            end
        end
        if (pin != prev_pin && !db_busy) begin
            if ((pin == PRESSED_LEVEL && !held) || (pin != PRESSED_LEVEL && held)) begin
                db_level = pin;
                db_busy  = 1'b1;
                db_count = '0;
            end
        end
        prev_pin = pin;
        down     = held;
    endtask

    // called at a rising edge; returns at the edge that takes the word
    task automatic send_sample(input logic pin, input logic typed, input t_gesture g,
                               input logic down);
        tick_result_t r;
        if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
            i_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(0, 99) < idle_pct);
        end
        i_valid     <= 1'b1;
        i_pin_level <= pin;
        do @(posedge i_clk); while (!o_ready);
        track_tick(pin, r.gesture, r.down);
        if (typed) begin
            r.gesture = g;
            r.down    = down;
        end
        tick_results.push_back(r);
        samples_sent++;
    endtask

    task automatic play_run(input logic level, input int n);
        repeat (n) send_sample(level, 1'b0, GESTURE_NONE, 1'b0);
    endtask

    // optional contact bounce ahead of a steady level
    task automatic shake_then_hold(input logic level, input int n);
        if ($urandom_range(0, 2) == 0) begin
            repeat ($urandom_range(1, 3)) begin
                send_sample(~level, 1'b0, GESTURE_NONE, 1'b0);
                send_sample(level, 1'b0, GESTURE_NONE, 1'b0);
            end
        end
        play_run(level, n);
    endtask

    task automatic settle();
        i_valid <= 1'b0;
        while (tick_results.size() != 0) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_index idx, input logic [LEN_WIDTH-1:0] data);
        settle();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            CFG_DEBOUNCE_TICKS:      cfg_debounce = data;
            CFG_LONG_PRESS_TICKS:    cfg_long     = data;
            CFG_DOUBLE_CLICK_TICKS:  cfg_double   = data;
            CFG_CLICK_ENABLE:        en_click     = data[0];
            CFG_DOUBLE_CLICK_ENABLE: en_double    = data[0];
            CFG_LONG_PRESS_ENABLE:   en_long      = data[0];
            default: ;
        endcase
    endtask

    always @(posedge i_clk) begin : result_check
        tick_result_t want;
        i_ready <= ($urandom_range(0, 99) >= stall_pct);
        if (i_rst_n && o_valid && i_ready) begin
            if (tick_results.size() == 0) begin
                $error("unexpected word: gesture %0d button_down %0d",
                       o_gesture, o_button_down);
                mismatches++;
            end else begin
                want = tick_results.pop_front();
                if (o_gesture !== want.gesture) begin
                    $error("gesture mismatch: expected %0d, got %0d", want.gesture, o_gesture);
                    mismatches++;
                end
                if (o_button_down !== want.down) begin
                    $error("button_down mismatch: expected %0d, got %0d",
                           want.down, o_button_down);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin : stimulus
        int                   k;
        int                   phase;
        int                   base;
        int                   dbn;
        int                   lpn;
        int                   dcn;
        int                   press_len;
        int                   gap_len;
        logic [LEN_WIDTH-1:0] len_pick;
        reset_tracker();
        i_rst_n     <= 1'b0;
        i_valid     <= 1'b0;
        i_pin_level <= ~PRESSED_LEVEL;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= CFG_DEBOUNCE_TICKS;
        i_cfg_data  <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (k = 0; k < NUM_STEPS; k++) begin
            if (DIRECTED_STEPS[k].is_cfg)
                write_reg(DIRECTED_STEPS[k].idx, DIRECTED_STEPS[k].data);
            else
                send_sample(DIRECTED_STEPS[k].pin, DIRECTED_STEPS[k].typed,
                            DIRECTED_STEPS[k].gesture, DIRECTED_STEPS[k].down);
        end

        // wider windows: one hold past the long press time, then a release
        idle_pct  = 0;
        stall_pct = 0;
        write_reg(CFG_DEBOUNCE_TICKS, 16'd12);
        write_reg(CFG_LONG_PRESS_TICKS, 16'd25);
        write_reg(CFG_DOUBLE_CLICK_TICKS, 16'd15);
        write_reg(CFG_LONG_PRESS_ENABLE, 16'h0001);
        play_run(PRESSED_LEVEL, LONG_HOLD);
        play_run(~PRESSED_LEVEL, 40);

        for (phase = 0; phase < NUM_PHASES; phase++) begin
            case (phase % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 72; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 72; end
                default: begin idle_pct = 23; stall_pct = 23; end
            endcase
            // short windows keep gestures to a few dozen words
            if (phase == 1 || phase == 2) begin
                len_pick = (phase == 1) ? 16'd0 : 16'd1;
                write_reg(CFG_DEBOUNCE_TICKS, len_pick);
                write_reg(CFG_LONG_PRESS_TICKS, len_pick);
                write_reg(CFG_DOUBLE_CLICK_TICKS, len_pick);
            end else begin
                write_reg(CFG_DEBOUNCE_TICKS, LEN_WIDTH'($urandom_range(0, 4)));
                write_reg(CFG_LONG_PRESS_TICKS, LEN_WIDTH'($urandom_range(0, 14)));
                write_reg(CFG_DOUBLE_CLICK_TICKS, LEN_WIDTH'($urandom_range(0, 10)));
            end
            write_reg(CFG_CLICK_ENABLE,
                      LEN_WIDTH'($urandom_range(0, 65535) | (phase % 3 == 0)));
            write_reg(CFG_DOUBLE_CLICK_ENABLE,
                      LEN_WIDTH'($urandom_range(0, 65535) | (phase % 3 == 0)));
            write_reg(CFG_LONG_PRESS_ENABLE,
                      LEN_WIDTH'($urandom_range(0, 65535) | (phase % 3 == 0)));

            dbn  = (cfg_debounce == 0) ? 1 : int'(cfg_debounce);
            lpn  = (cfg_long == 0) ? 1 : int'(cfg_long);
            dcn  = (cfg_double == 0) ? 1 : int'(cfg_double);
            base = samples_sent;
            while (samples_sent - base < PHASE_WORDS) begin
                if ($urandom_range(0, 7) == 0) begin
                    repeat ($urandom_range(1, 8))
                        send_sample(1'($urandom_range(0, 1)), 1'b0, GESTURE_NONE, 1'b0);
                end else begin
                    case ($urandom_range(0, 3))
                        0:       press_len = int'($urandom_range(1, dbn));
                        1:       press_len = dbn + lpn + int'($urandom_range(1, 4));
                        default: press_len = dbn + int'($urandom_range(1, lpn));
                    endcase
                    // a short gap lets the next press turn into a double click
                    if ($urandom_range(0, 1) == 0)
                        gap_len = dbn + 1 + int'($urandom_range(0, dcn));
                    else
                        gap_len = dbn + dcn + int'($urandom_range(1, 6));
                    shake_then_hold(PRESSED_LEVEL, press_len);
                    shake_then_hold(~PRESSED_LEVEL, gap_len);
                end
            end
        end

        settle();
        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
